FILE: rtl/sia_pkg.sv
// Shared types, codes and constants of the signed integer arithmetic unit.
package sia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        OP_SUCC = 3'd0,
        OP_PRED = 3'd1,
        OP_NEG  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_MUL  = 3'd5,
        OP_DIV  = 3'd6,
        OP_POW  = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_POW_CHK,
        S_POW_ACC,
        S_POW_ACC_WR,
        S_POW_SQ,
        S_POW_SQ_WR,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MSEL_AB,
        MSEL_ACC_SQ,
        MSEL_SQ_SQ
    } t_msel;

    typedef enum logic [2:0] {
        RSEL_ALU,
        RSEL_PROD,
        RSEL_QUO,
        RSEL_ACC,
        RSEL_ZERO
    } t_rsel;

    typedef struct packed {
        logic  load;
        logic  mul_init;
        t_msel msel;
        logic  mul_step;
        logic  div_init;
        logic  div_step;
        logic  acc_wr;
        logic  sq_wr;
        logic  exp_shift;
        logic  finish;
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic b_zero;
        logic b_neg;
        logic exp_zero;
        logic exp_lsb;
    } t_sts;

    typedef struct packed {
        t_op                          op;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         undefined_case;
    } t_out_beat;

endpackage

FILE: rtl/signed_integer_arith_unit.sv
// Signed integer arithmetic unit: top level joining the sequencer and the datapath.
// succ, pred, neg, add and sub go through the ALU; mul and div each take one 32-step
// pass of the shared shift-add/restoring unit. Power runs square-and-multiply on the
// same unit: a squaring pass per exponent bit, plus a multiply pass when the bit is
// set. One item is in flight at a time; the output register lets the next input beat
// be taken while a result waits. Reset clears control.
module signed_integer_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sia_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sia_pkg::t_out_beat o_out_beat
);
    import sia_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sia_dp u_dp (
        .i_clk      (i_clk),
        .i_in_beat  (i_in_beat),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_beat (o_out_beat)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_flag_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.undefined_case) |-> (o_out_beat.result == '0))
        else $error("undefined case with nonzero result");

    a_ready_drop_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid))
        else $error("ready dropped without an input beat");

endmodule

FILE: rtl/sia_ctrl.sv
// Sequencer of the arithmetic unit: decodes the operation and steps the shared datapath.
module sia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sia_pkg::t_sts i_sts,
    output sia_pkg::t_cmd o_cmd
);
    import sia_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_rsel             r_rsel, n_rsel;
    logic              r_ovalid, n_ovalid;
    logic              last;

    assign last        = (r_cnt == CNT_W'(DATA_WIDTH - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rsel   <= RSEL_ALU;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rsel   <= n_rsel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rsel   = r_rsel;
        n_ovalid = r_ovalid & ~i_out_ready;
        o_cmd    = '0;
        o_cmd.msel = MSEL_AB;
        o_cmd.rsel = r_rsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                case (i_sts.op)
                    OP_MUL: begin
                        o_cmd.mul_init = 1'b1;
                        o_cmd.msel     = MSEL_AB;
                        n_state        = S_MUL;
                    end
                    OP_DIV: begin
                        if (i_sts.b_zero) begin
                            n_rsel  = RSEL_ZERO;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (i_sts.b_neg) begin
                            n_rsel  = RSEL_ZERO;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_POW_CHK;
                        end
                    end
                    default: begin
                        n_rsel  = RSEL_ALU;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_rsel  = RSEL_PROD;
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_rsel  = RSEL_QUO;
                    n_state = S_FIN;
                end
            end
            S_POW_CHK: begin
                n_cnt = '0;
                if (i_sts.exp_zero) begin
                    n_rsel  = RSEL_ACC;
                    n_state = S_FIN;
                end else if (i_sts.exp_lsb) begin
                    o_cmd.mul_init = 1'b1;
                    o_cmd.msel     = MSEL_ACC_SQ;
                    n_state        = S_POW_ACC;
                end else begin
                    o_cmd.mul_init = 1'b1;
                    o_cmd.msel     = MSEL_SQ_SQ;
                    n_state        = S_POW_SQ;
                end
            end
            S_POW_ACC: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_POW_ACC_WR;
                end
            end
            S_POW_ACC_WR: begin
                o_cmd.acc_wr   = 1'b1;
                o_cmd.mul_init = 1'b1;
                o_cmd.msel     = MSEL_SQ_SQ;
                n_cnt          = '0;
                n_state        = S_POW_SQ;
            end
            S_POW_SQ: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    n_state = S_POW_SQ_WR;
                end
            end
            S_POW_SQ_WR: begin
                o_cmd.sq_wr     = 1'b1;
                o_cmd.exp_shift = 1'b1;
                n_state         = S_POW_CHK;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sia_dp.sv
// Datapath of the arithmetic unit: operand registers, shared shift-add/restoring unit, result register.
module sia_dp (
    input  logic               i_clk,
    input  sia_pkg::t_in_beat  i_in_beat,
    input  sia_pkg::t_cmd      i_cmd,
    output sia_pkg::t_sts      o_sts,
    output sia_pkg::t_out_beat o_out_beat
);
    import sia_pkg::*;

    localparam int W = DATA_WIDTH;

    t_op          r_op;
    logic [W-1:0] r_a, r_b;
    logic [W-1:0] r_sq, r_acc, r_exp;
    logic [W-1:0] r_x, r_y, r_p;
    logic [W-1:0] r_res;
    logic         r_flag;

    logic [W-1:0] mag_a, mag_b;
    logic [W:0]   n_trial;
    logic         qbit;
    logic [W-1:0] n_rem;
    logic [W-1:0] alu_res;
    logic [W-1:0] n_res;

    assign mag_a = r_a[W-1] ? ('0 - r_a) : r_a;
    assign mag_b = r_b[W-1] ? ('0 - r_b) : r_b;

    assign n_trial = {r_p, r_x[W-1]} - {1'b0, r_y};
    assign qbit    = ~n_trial[W];
    assign n_rem   = qbit ? n_trial[W-1:0] : {r_p[W-2:0], r_x[W-1]};

    always_comb begin
        case (r_op)
            OP_SUCC: alu_res = r_a + W'(1);
            OP_PRED: alu_res = r_a - W'(1);
            OP_NEG:  alu_res = '0 - r_a;
            OP_ADD:  alu_res = r_a + r_b;
            OP_SUB:  alu_res = r_a - r_b;
            default: alu_res = r_a;
        endcase
    end

    always_comb begin
        case (i_cmd.rsel)
            RSEL_ALU:  n_res = alu_res;
            RSEL_PROD: n_res = r_p;
            RSEL_QUO:  n_res = (r_a[W-1] ^ r_b[W-1]) ? ('0 - r_x) : r_x;
            RSEL_ACC:  n_res = r_acc;
            default:   n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_beat.op;
            r_a   <= i_in_beat.operand_a;
            r_b   <= i_in_beat.operand_b;
            r_sq  <= i_in_beat.operand_a;
            r_acc <= W'(1);
            r_exp <= i_in_beat.operand_b;
        end
        if (i_cmd.mul_init) begin
            case (i_cmd.msel)
                MSEL_AB: begin
                    r_x <= r_a;
                    r_y <= r_b;
                end
                MSEL_ACC_SQ: begin
                    r_x <= r_acc;
                    r_y <= r_sq;
                end
                default: begin
                    r_x <= r_sq;
                    r_y <= r_sq;
                end
            endcase
            r_p <= '0;
        end
        if (i_cmd.div_init) begin
            r_x <= mag_a;
            r_y <= mag_b;
            r_p <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_y[0]) begin
                r_p <= r_p + r_x;
            end
            r_x <= {r_x[W-2:0], 1'b0};
            r_y <= {1'b0, r_y[W-1:1]};
        end
        if (i_cmd.div_step) begin
            r_p <= n_rem;
            r_x <= {r_x[W-2:0], qbit};
        end
        if (i_cmd.acc_wr) begin
            r_acc <= r_p;
        end
        if (i_cmd.sq_wr) begin
            r_sq <= r_p;
        end
        if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
        if (i_cmd.finish) begin
            r_res  <= n_res;
            r_flag <= (i_cmd.rsel == RSEL_ZERO);
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.b_neg    = r_b[W-1];
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];

    assign o_out_beat.result         = r_res;
    assign o_out_beat.undefined_case = r_flag;

endmodule

FILE: bench/sia_result_checker.sv
// Checker for the signed integer arithmetic unit: predicts each result and compares beats.
module sia_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  sia_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sia_pkg::t_out_beat i_out_beat,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);
    import sia_pkg::*;

    t_out_beat expected_results[$];
    t_out_beat want;

    function automatic t_out_beat compute_arith_result(t_in_beat beat);
        logic [DATA_WIDTH-1:0] a, b, mag_a, mag_b, quo, acc, sq;
        t_out_beat res;
        a = beat.operand_a;
        b = beat.operand_b;
        res.result         = '0;
        res.undefined_case = 1'b0;
        case (beat.op)
            OP_SUCC: res.result = a + 1;
            OP_PRED: res.result = a - 1;
            OP_NEG:  res.result = -a;
            OP_ADD:  res.result = a + b;
            OP_SUB:  res.result = a - b;
            OP_MUL:  res.result = a * b;
            OP_DIV: begin
                if (b == '0) begin
                    res.undefined_case = 1'b1;
                end else begin
                    mag_a = a[DATA_WIDTH-1] ? -a : a;
                    mag_b = b[DATA_WIDTH-1] ? -b : b;
                    quo   = mag_a / mag_b;
                    res.result = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
                end
            end
            OP_POW: begin
                if (b[DATA_WIDTH-1]) begin
                    res.undefined_case = 1'b1;
                end else begin
                    acc = 1;
                    sq  = a;
                    for (int i = 0; i < DATA_WIDTH - 1; i++) begin
                        if (b[i]) begin
                            acc = acc * sq;
                        end
                        sq = sq * sq;
                    end
                    res.result = acc;
                end
            end
            default: begin
                res.result = '0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors  = 0;
            o_pending = 0;
            o_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                                              i_out_beat.result));
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_out_beat.result !== want.result) begin
                        report_mismatch($sformatf("result %0d, expected %0d",
                                                  i_out_beat.result, want.result));
                    end
                    if (i_out_beat.undefined_case !== want.undefined_case) begin
                        report_mismatch($sformatf("undefined_case %b, expected %b",
                                                  i_out_beat.undefined_case,
                                                  want.undefined_case));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(compute_arith_result(i_in_beat));
            end
            o_pending = expected_results.size();
        end
    end

endmodule

FILE: bench/tb_signed_integer_arith_unit.sv
// Testbench top for the signed integer arithmetic unit: clock, reset, stimulus and verdict.
module tb_signed_integer_arith_unit;
    import sia_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam logic signed [DATA_WIDTH-1:0] MAX_S = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_S = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;

    int errors;
    int pending;
    int checked;
    int sent     = 0;
    int cycles   = 0;
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    bit hold_on  = 1'b0;

    signed_integer_arith_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    sia_result_checker u_result_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_beat  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_signed_integer_arith_unit NOT OK");
            $finish;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3:       return $signed($urandom_range(0, 40)) - 20;
            4: begin
                case ($urandom_range(0, 4))
                    0:       return MAX_S;
                    1:       return MIN_S;
                    2:       return 0;
                    3:       return 1;
                    default: return -1;
                endcase
            end
            5:       return 1 << $urandom_range(0, DATA_WIDTH - 1);
            6:       return -(1 << $urandom_range(0, DATA_WIDTH - 1));
            default: return $urandom >> $urandom_range(0, DATA_WIDTH - 1);
        endcase
    endfunction

    task automatic send_beat(t_op op, logic signed [DATA_WIDTH-1:0] a,
                             logic signed [DATA_WIDTH-1:0] b);
        t_in_beat beat;
        int gap;
        beat.op        = op;
        beat.operand_a = a;
        beat.operand_b = b;
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_item();
        t_op op;
        logic signed [DATA_WIDTH-1:0] a, b;
        op = t_op'($urandom_range(0, 7));
        a  = pick_operand();
        b  = pick_operand();
        if (op == OP_POW) begin
            // keep most exponents short; full-width ones are slow
            case ($urandom_range(0, 15))
                0:       b = $urandom | MIN_S;
                1:       b = $urandom & MAX_S;
                default: b = $urandom_range(0, 40);
            endcase
        end else if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            b = '0;
        end
        send_beat(op, a, b);
    endtask

    initial begin
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            if (hold_req && !hold_on) begin
                @(negedge clk) out_ready <= 1'b0;
                hold_on = 1'b1;
                repeat (300) @(negedge clk);
                hold_on = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                @(negedge clk) out_ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            @(negedge clk) out_ready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    initial begin
        in_valid = 1'b0;
        in_beat  = '0;
        rst_n    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_beat(OP_SUCC, MAX_S, MIN_S);
        send_beat(OP_PRED, MIN_S, MAX_S);
        send_beat(OP_NEG, MIN_S, 0);
        send_beat(OP_NEG, 0, -1);
        send_beat(OP_ADD, MAX_S, 1);
        send_beat(OP_SUB, MIN_S, 1);
        send_beat(OP_MUL, MAX_S, MAX_S);
        send_beat(OP_MUL, MIN_S, -1);
        send_beat(OP_DIV, 12345, 0);
        send_beat(OP_DIV, MIN_S, -1);
        send_beat(OP_DIV, -7, 2);
        send_beat(OP_DIV, 7, -2);
        send_beat(OP_DIV, -7, -2);
        send_beat(OP_DIV, MIN_S, MIN_S);
        send_beat(OP_DIV, 5, 7);
        send_beat(OP_DIV, MAX_S, MIN_S);
        send_beat(OP_POW, 0, 0);
        send_beat(OP_POW, MIN_S, 0);
        send_beat(OP_POW, 5, -1);
        send_beat(OP_POW, 2, 31);
        send_beat(OP_POW, -3, 5);
        send_beat(OP_POW, 3, MAX_S);
        send_beat(OP_POW, 0, 7);
        send_beat(OP_POW, -1, MAX_S);

        for (int i = 0; i < 100; i++) begin
            send_random_item();
        end

        // stall the output long enough to back up the input
        hold_req = 1'b1;
        wait (hold_on);
        hold_req = 1'b0;
        quiet = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_beat($urandom_range(0, 1) ? OP_ADD : OP_SUB, pick_operand(), pick_operand());
        end
        quiet = 1'b0;
        @(negedge clk) in_valid <= 1'b0;
        wait (pending == 0);

        for (int i = 0; i < 110; i++) begin
            send_random_item();
        end

        quiet = 1'b1;
        for (int i = 0; i < 44; i++) begin
            send_random_item();
        end

        @(negedge clk) in_valid <= 1'b0;
        wait (pending == 0);
        repeat (64) @(posedge clk);

        $display("run: %0d operand beats over all eight operations, %0d results checked",
                 sent, checked);
        $display("covered: wraparound, divide by zero, divide signs, zero and negative "
                 , "exponents, random stalls and a long output hold-off");
        if (errors == 0) begin
            $display("tb_signed_integer_arith_unit OK");
        end else begin
            $display("tb_signed_integer_arith_unit NOT OK");
        end
        $finish;
    end

endmodule
